// ----- hw/rtl/rpll_pkg.sv -----
package rpll_pkg;

   // field widths
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 8;
   localparam int SEL_W   = 3;
   localparam int PORT_W  = 10;
   localparam int DEPTH_W = 3;
   localparam int HZ_W    = 30;
   localparam int WORD_W  = 16;
   localparam int IDX_W   = 8;

   // access direction
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // bus register map: 0..3 belong to the VGA DAC, 4..7 to this unit
   localparam logic [ADDR_W-1:0] ADDR_PEL_WIDX = 3'd0;
   localparam logic [ADDR_W-1:0] ADDR_PEL_DATA = 3'd1;
   localparam logic [ADDR_W-1:0] ADDR_PEL_MASK = 3'd2;
   localparam logic [ADDR_W-1:0] ADDR_PEL_RIDX = 3'd3;
   localparam logic [ADDR_W-1:0] ADDR_PLL_WIDX = 3'd4;
   localparam logic [ADDR_W-1:0] ADDR_PLL_DATA = 3'd5;
   localparam logic [ADDR_W-1:0] ADDR_COMMAND  = 3'd6;
   localparam logic [ADDR_W-1:0] ADDR_PLL_RIDX = 3'd7;

   // VGA DAC port bases for forwarded accesses
   localparam logic [PORT_W-1:0] VGA_PORT_LOW_BASE  = 10'h3c8;
   localparam logic [PORT_W-1:0] VGA_PORT_HIGH_BASE = 10'h3c4;

   // hidden command unlock sequence
   localparam logic [DATA_W-1:0] DAC_ID           = 8'h70;
   localparam logic [2:0]        HIDDEN_ID_COUNT  = 3'd4;
   localparam logic [2:0]        HIDDEN_CMD_COUNT = 3'd5;

   // PLL store
   localparam logic [WORD_W-1:0] ENTRY0_RESET = 16'h6128;
   localparam logic [WORD_W-1:0] ENTRY1_RESET = 16'h623d;
   localparam logic [IDX_W-1:0]  PLL_IDX_EXT  = 8'h0a;
   localparam logic [IDX_W-1:0]  PLL_IDX_CTRL = 8'h0e;
   localparam int                OVR_EN_BIT   = 5;

   // clock sources and PLL arithmetic
   localparam logic [SEL_W-1:0] SRC_FIXED0 = 3'd0;
   localparam logic [SEL_W-1:0] SRC_FIXED1 = 3'd1;
   localparam logic [23:0]      XTAL_HZ    = 24'd14318184;
   localparam logic [HZ_W-1:0]  CLK0_HZ    = 30'd25175000;
   localparam logic [HZ_W-1:0]  CLK1_HZ    = 30'd28322000;
   localparam int               M_W        = 8;
   localparam int               NUMER_W    = 31;
   localparam int               DIVR_W     = 6;
   localparam int               STEP_W     = $clog2(NUMER_W);

   // pixel depth codes
   localparam logic [DEPTH_W-1:0] DEPTH_8  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_15 = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_16 = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_24 = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_32 = 3'd4;

   // sequencing strobes into the register file
   typedef struct packed {
      logic load;
      logic exec;
      logic clkrd;
   } regs_ctl_type;

   // register file results for one item
   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               forwarded;
      logic [PORT_W-1:0]  vga_port;
      logic [DEPTH_W-1:0] pixel_depth;
      logic [SEL_W-1:0]   clk_src;
      logic [WORD_W-1:0]  clk_word;
   } regs_stat_type;

   // request to the clock unit
   typedef struct packed {
      logic              start;
      logic [SEL_W-1:0]  src;
      logic [WORD_W-1:0] word;
   } clk_req_type;

   function automatic logic [DEPTH_W-1:0] depth_decode(input logic [3:0] nib);
      logic [DEPTH_W-1:0] d;
      unique case (nib)
         4'h2, 4'h3, 4'h8, 4'ha: d = DEPTH_15;
         4'h5, 4'h6, 4'hc:       d = DEPTH_16;
         4'h4, 4'h9, 4'he:       d = DEPTH_24;
         4'h7:                   d = DEPTH_32;
         default:                d = DEPTH_8;
      endcase
      return d;
   endfunction

endpackage

// ----- hw/rtl/rpll_if.sv -----
// bus access channel
interface rpll_req_if;
   import rpll_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;
   logic [SEL_W-1:0]  clock_select;

   modport source (output valid, action, address, write_data, clock_select, input ready);
   modport sink   (input valid, action, address, write_data, clock_select, output ready);
endinterface

// result channel
interface rpll_rsp_if;
   import rpll_pkg::*;
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  read_data;
   logic               forwarded;
   logic [PORT_W-1:0]  vga_port;
   logic [DEPTH_W-1:0] pixel_depth;
   logic [HZ_W-1:0]    pixel_clock_hz;

   modport source (output valid, read_data, forwarded, vga_port, pixel_depth, pixel_clock_hz,
                   input ready);
   modport sink   (input valid, read_data, forwarded, vga_port, pixel_depth, pixel_clock_hz,
                   output ready);
endinterface

// ----- hw/rtl/rpll_regs.sv -----
module rpll_regs import rpll_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  regs_ctl_type       ctl,
   input  logic               acc_action,
   input  logic [ADDR_W-1:0]  acc_address,
   input  logic [DATA_W-1:0]  acc_data,
   input  logic [SEL_W-1:0]   acc_clock_select,
   output regs_stat_type      stat
);

   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_EXT  = 3'd6;
   localparam logic [SLOT_W-1:0] SLOT_CTRL = 3'd7;

   function automatic logic is_writable(input logic [IDX_W-1:0] idx);
      return (idx >= 8'd2 && idx <= 8'd7) || idx == PLL_IDX_EXT || idx == PLL_IDX_CTRL;
   endfunction

   // writable entries 2..7 sit in slots 0..5, then 0x0a and 0x0e
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [SLOT_W-1:0] s;
      if (idx == PLL_IDX_EXT) begin
         s = SLOT_EXT;
      end else if (idx == PLL_IDX_CTRL) begin
         s = SLOT_CTRL;
      end else begin
         s = SLOT_W'(idx - 8'd2);
      end
      return s;
   endfunction

   // fixed value of entries that have no storage
   function automatic logic [WORD_W-1:0] base_of(input logic [IDX_W-1:0] idx);
      logic [WORD_W-1:0] b;
      if (idx == 8'd0) begin
         b = ENTRY0_RESET;
      end else if (idx == 8'd1) begin
         b = ENTRY1_RESET;
      end else begin
         b = '0;
      end
      return b;
   endfunction

   logic [WORD_W-1:0]    mem [NUM_SLOTS];

   logic                 acc_action_ff;
   logic [ADDR_W-1:0]    acc_address_ff;
   logic [DATA_W-1:0]    acc_data_ff;
   logic [SEL_W-1:0]     sel_ff;

   logic [DATA_W-1:0]    command_ff, command_in;
   logic [2:0]           count_ff, count_in;
   logic                 toggle_ff, toggle_in;
   logic [IDX_W-1:0]     widx_ff, widx_in;
   logic [IDX_W-1:0]     ridx_ff, ridx_in;
   logic                 ovr_en_ff, ovr_en_in;
   logic [SEL_W-1:0]     ovr_src_ff, ovr_src_in;
   logic [NUM_SLOTS-1:0] vlo_ff, vlo_in;
   logic [NUM_SLOTS-1:0] vhi_ff, vhi_in;

   logic [WORD_W-1:0]    rd_raw_ff;
   logic                 rd_vlo_ff;
   logic                 rd_vhi_ff;
   logic [WORD_W-1:0]    rd_base_ff;
   logic [WORD_W-1:0]    rd_word;

   logic [DATA_W-1:0]    read_data_ff, read_data_in;
   logic                 fwd_ff, fwd_in;
   logic [PORT_W-1:0]    vga_port_ff, vga_port_in;

   logic [SEL_W-1:0]     clk_src;
   logic [IDX_W-1:0]     ra_idx;
   logic [SLOT_W-1:0]    rslot;
   logic [SLOT_W-1:0]    wslot;
   logic                 wr_lo, wr_hi;
   logic [2:0]           cnt_up;

   // clock source, with the override held in entry 0x0e
   assign clk_src = ovr_en_ff ? ovr_src_ff : sel_ff;

   // one read port: data entry at load, clock source entry afterwards
   assign ra_idx = ctl.clkrd ? IDX_W'(clk_src) : ridx_ff;
   assign rslot  = slot_of(ra_idx);
   assign wslot  = slot_of(widx_ff);

   always_ff @(posedge clock) begin
      if (ctl.load || ctl.clkrd) begin
         rd_raw_ff  <= mem[rslot];
         rd_vlo_ff  <= is_writable(ra_idx) && vlo_ff[rslot];
         rd_vhi_ff  <= is_writable(ra_idx) && vhi_ff[rslot];
         rd_base_ff <= base_of(ra_idx);
      end
   end

   // lanes never written read as their reset value
   assign rd_word = {rd_vhi_ff ? rd_raw_ff[15:8] : rd_base_ff[15:8],
                     rd_vlo_ff ? rd_raw_ff[7:0]  : rd_base_ff[7:0]};

   // byte lane writes
   always_ff @(posedge clock) begin
      if (wr_lo) begin
         mem[wslot][7:0] <= acc_data_ff;
      end
      if (wr_hi) begin
         mem[wslot][15:8] <= acc_data_ff;
      end
   end

   // latch the access
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         acc_action_ff  <= acc_action;
         acc_address_ff <= acc_address;
         acc_data_ff    <= acc_data;
         sel_ff         <= acc_clock_select;
      end
   end

   // execute the access
   always_comb begin
      command_in   = command_ff;
      count_in     = count_ff;
      toggle_in    = toggle_ff;
      widx_in      = widx_ff;
      ridx_in      = ridx_ff;
      ovr_en_in    = ovr_en_ff;
      ovr_src_in   = ovr_src_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      wr_lo        = 1'b0;
      wr_hi        = 1'b0;
      read_data_in = '0;
      fwd_in       = 1'b0;
      cnt_up       = (count_ff < HIDDEN_CMD_COUNT) ? count_ff + 3'd1 : count_ff;
      if (acc_action_ff == ACT_WRITE) begin
         fwd_in = acc_address_ff < ADDR_PLL_WIDX;
         unique case (acc_address_ff)
            ADDR_PEL_MASK: begin
               if (count_ff == HIDDEN_ID_COUNT) begin
                  command_in = acc_data_ff;
               end
               count_in = '0;
            end
            ADDR_PEL_WIDX, ADDR_PEL_DATA, ADDR_PEL_RIDX: begin
               count_in = '0;
            end
            ADDR_PLL_WIDX: begin
               widx_in   = acc_data_ff;
               toggle_in = 1'b0;
            end
            ADDR_PLL_DATA: begin
               if (is_writable(widx_ff)) begin
                  wr_lo = !toggle_ff;
                  wr_hi = toggle_ff;
                  if (wr_lo) begin
                     vlo_in[wslot] = 1'b1;
                  end
                  if (wr_hi) begin
                     vhi_in[wslot] = 1'b1;
                  end
                  if (widx_ff == PLL_IDX_CTRL && !toggle_ff) begin
                     ovr_en_in  = acc_data_ff[OVR_EN_BIT];
                     ovr_src_in = acc_data_ff[SEL_W-1:0];
                  end
               end
               toggle_in = !toggle_ff;
               if (toggle_ff) begin
                  widx_in = widx_ff + 8'd1;
               end
            end
            ADDR_COMMAND: begin
               command_in = acc_data_ff;
            end
            ADDR_PLL_RIDX: begin
               ridx_in   = acc_data_ff;
               toggle_in = 1'b0;
            end
         endcase
      end else begin
         unique case (acc_address_ff)
            ADDR_PEL_MASK: begin
               count_in = cnt_up;
               if (cnt_up == HIDDEN_ID_COUNT) begin
                  read_data_in = DAC_ID;
               end else if (cnt_up == HIDDEN_CMD_COUNT) begin
                  count_in     = '0;
                  read_data_in = command_ff;
               end else begin
                  fwd_in = 1'b1;
               end
            end
            ADDR_PEL_WIDX, ADDR_PEL_DATA, ADDR_PEL_RIDX: begin
               count_in = '0;
               fwd_in   = 1'b1;
            end
            ADDR_PLL_WIDX: begin
               read_data_in = widx_ff;
            end
            ADDR_PLL_DATA: begin
               read_data_in = toggle_ff ? rd_word[15:8] : rd_word[7:0];
               toggle_in    = !toggle_ff;
               if (toggle_ff) begin
                  ridx_in = ridx_ff + 8'd1;
               end
            end
            ADDR_COMMAND: begin
               read_data_in = command_ff;
            end
            ADDR_PLL_RIDX: begin
               read_data_in = ridx_ff;
            end
         endcase
      end
      if (!ctl.exec) begin
         wr_lo = 1'b0;
         wr_hi = 1'b0;
      end
      if (!fwd_in) begin
         vga_port_in = '0;
      end else if (acc_address_ff < ADDR_PEL_MASK) begin
         vga_port_in = VGA_PORT_LOW_BASE + PORT_W'(acc_address_ff);
      end else begin
         vga_port_in = VGA_PORT_HIGH_BASE + PORT_W'(acc_address_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
         count_ff   <= '0;
         toggle_ff  <= 1'b0;
         widx_ff    <= '0;
         ridx_ff    <= '0;
         ovr_en_ff  <= 1'b0;
         ovr_src_ff <= '0;
         vlo_ff     <= '0;
         vhi_ff     <= '0;
      end else if (ctl.exec) begin
         command_ff <= command_in;
         count_ff   <= count_in;
         toggle_ff  <= toggle_in;
         widx_ff    <= widx_in;
         ridx_ff    <= ridx_in;
         ovr_en_ff  <= ovr_en_in;
         ovr_src_ff <= ovr_src_in;
         vlo_ff     <= vlo_in;
         vhi_ff     <= vhi_in;
      end
   end

   // per-item results
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         read_data_ff <= read_data_in;
         fwd_ff       <= fwd_in;
         vga_port_ff  <= vga_port_in;
      end
   end

   assign stat.read_data   = read_data_ff;
   assign stat.forwarded   = fwd_ff;
   assign stat.vga_port    = vga_port_ff;
   assign stat.pixel_depth = depth_decode(command_ff[7:4]);
   assign stat.clk_src     = clk_src;
   assign stat.clk_word    = rd_word;

endmodule

// ----- hw/rtl/rpll_clk.sv -----
module rpll_clk import rpll_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  clk_req_type     req,
   output logic            done,
   output logic [HZ_W-1:0] hz
);

   typedef enum logic [2:0] {
      CK_IDLE = 3'b001,
      CK_DIV  = 3'b010,
      CK_FIN  = 3'b100
   } ck_state_type;

   ck_state_type        state_ff, state_in;
   logic                done_ff, done_in;
   logic [NUMER_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [DIVR_W-1:0]   div_ff, div_in;
   logic [2:0]          sh_ff, sh_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [HZ_W-1:0]     hz_ff, hz_in;

   logic [M_W-1:0]      m_val;
   logic [31:0]         prod_full;
   logic [DIVR_W+1:0]   trial;

   // numerator: crystal times (m + 2)
   assign m_val     = {1'b0, req.word[6:0]} + M_W'(2);
   assign prod_full = 32'(XTAL_HZ) * 32'(m_val);

   // one restoring step: bring in the next dividend bit
   assign trial = {1'b0, rem_ff, quo_ff[NUMER_W-1]} - {2'b00, div_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      sh_in    = sh_ff;
      step_in  = step_ff;
      hz_in    = hz_ff;
      unique case (state_ff)
         CK_IDLE: begin
            if (req.start) begin
               if (req.src == SRC_FIXED0) begin
                  hz_in   = CLK0_HZ;
                  done_in = 1'b1;
               end else if (req.src == SRC_FIXED1) begin
                  hz_in   = CLK1_HZ;
                  done_in = 1'b1;
               end else begin
                  quo_in   = prod_full[NUMER_W-1:0];
                  rem_in   = '0;
                  div_in   = {1'b0, req.word[12:8]} + DIVR_W'(2);
                  sh_in    = req.word[15:13];
                  step_in  = STEP_W'(NUMER_W - 1);
                  state_in = CK_DIV;
               end
            end
         end
         CK_DIV: begin
            if (!trial[DIVR_W+1]) begin
               rem_in = trial[DIVR_W-1:0];
            end else begin
               rem_in = {rem_ff[DIVR_W-2:0], quo_ff[NUMER_W-1]};
            end
            quo_in  = {quo_ff[NUMER_W-2:0], !trial[DIVR_W+1]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = CK_FIN;
            end
         end
         CK_FIN: begin
            // post divider is a power of two
            hz_in    = HZ_W'(quo_ff >> sh_ff);
            done_in  = 1'b1;
            state_in = CK_IDLE;
         end
         default: begin
            state_in = CK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      sh_ff   <= sh_in;
      step_ff <= step_in;
      hz_ff   <= hz_in;
   end

   assign done = done_ff;
   assign hz   = hz_ff;

endmodule

// ----- hw/rtl/ramdac_pll_register_interface_unit.sv -----
// RAMDAC register port with PLL pixel clock readout. Each bus access item
// yields one result item and is finished before the next is accepted. With
// a programmed PLL source the pixel clock is 14318184 * m / (n1 * 2^n2), and
// the division runs through a restoring divider that produces one quotient
// bit per cycle over the 31-bit product; fixed sources 0 and 1 skip the
// divider. One item is in work at a time; a finished result waits in the
// output register while the next item is already accepted and executed.
// Accesses to addresses 0 to 3, but for the hidden ID and command reads of
// the mask port, are returned flagged for the VGA DAC with its port number.
module ramdac_pll_register_interface_unit import rpll_pkg::*; (
   input logic         clock,
   input logic         reset,
   rpll_req_if.sink    req_ch,
   rpll_rsp_if.source  rsp_ch
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_CLKRD = 6'b000100,
      ST_START = 6'b001000,
      ST_CALC  = 6'b010000,
      ST_HOLD  = 6'b100000
   } top_state_type;

   top_state_type      state_ff, state_in;
   regs_ctl_type       ctl;
   regs_stat_type      stat;
   clk_req_type        clk_req;
   logic               clk_done;
   logic [HZ_W-1:0]    clk_hz;
   logic               accept;
   logic               out_free;
   logic               out_load;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_read_data_ff;
   logic               rsp_forwarded_ff;
   logic [PORT_W-1:0]  rsp_vga_port_ff;
   logic [DEPTH_W-1:0] rsp_pixel_depth_ff;
   logic [HZ_W-1:0]    rsp_pixel_clock_hz_ff;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.load = accept;
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = ST_CLKRD;
         end
         ST_CLKRD: begin
            ctl.clkrd = 1'b1;
            state_in  = ST_START;
         end
         ST_START: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (clk_done) begin
               out_load = out_free;
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            out_load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign clk_req.start = (state_ff == ST_START);
   assign clk_req.src   = stat.clk_src;
   assign clk_req.word  = stat.clk_word;

   rpll_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .acc_action       (req_ch.action),
      .acc_address      (req_ch.address),
      .acc_data         (req_ch.write_data),
      .acc_clock_select (req_ch.clock_select),
      .stat             (stat)
   );

   rpll_clk u_clk (
      .clock (clock),
      .reset (reset),
      .req   (clk_req),
      .done  (clk_done),
      .hz    (clk_hz)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_read_data_ff      <= stat.read_data;
         rsp_forwarded_ff      <= stat.forwarded;
         rsp_vga_port_ff       <= stat.vga_port;
         rsp_pixel_depth_ff    <= stat.pixel_depth;
         rsp_pixel_clock_hz_ff <= clk_hz;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.read_data      = rsp_read_data_ff;
   assign rsp_ch.forwarded      = rsp_forwarded_ff;
   assign rsp_ch.vga_port       = rsp_vga_port_ff;
   assign rsp_ch.pixel_depth    = rsp_pixel_depth_ff;
   assign rsp_ch.pixel_clock_hz = rsp_pixel_clock_hz_ff;

endmodule

// ----- hw/rtl/rpll_checker.sv -----
module rpll_props import rpll_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DATA_W-1:0]  rsp_read_data,
   input logic               rsp_forwarded,
   input logic [PORT_W-1:0]  rsp_vga_port,
   input logic [DEPTH_W-1:0] rsp_pixel_depth,
   input logic [HZ_W-1:0]    rsp_pixel_clock_hz
);

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // only forwarded accesses carry a port number
   a_port_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forwarded |-> rsp_vga_port == '0)
      else $error("port number on a local access");

   // forwarded accesses return no data and map to the four DAC ports
   a_fwd_port: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forwarded |-> rsp_read_data == '0 &&
         (rsp_vga_port == 10'h3c8 || rsp_vga_port == 10'h3c9 ||
          rsp_vga_port == 10'h3c6 || rsp_vga_port == 10'h3c7))
      else $error("bad forwarded item");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
         $stable(rsp_forwarded) && $stable(rsp_vga_port) &&
         $stable(rsp_pixel_depth) && $stable(rsp_pixel_clock_hz))
      else $error("stalled result changed");

endmodule

bind ramdac_pll_register_interface_unit rpll_props u_rpll_props (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_read_data      (rsp_ch.read_data),
   .rsp_forwarded      (rsp_ch.forwarded),
   .rsp_vga_port       (rsp_ch.vga_port),
   .rsp_pixel_depth    (rsp_ch.pixel_depth),
   .rsp_pixel_clock_hz (rsp_ch.pixel_clock_hz)
);

// ----- tb/rpll_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels, predicts each result item and compares it.
module rpll_checker import rpll_pkg::*; (
   input  logic clock,
   input  logic reset,
   rpll_req_if  req_ch,
   rpll_rsp_if  rsp_ch,
   output int   results_seen,
   output int   fail_count
);

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               forwarded;
      logic [PORT_W-1:0]  vga_port;
      logic [DEPTH_W-1:0] pixel_depth;
      logic [HZ_W-1:0]    pixel_clock_hz;
   } ramdac_result_type;

   ramdac_result_type pending_results[$];

   // predicted register state
   logic [DATA_W-1:0] cmd_reg;
   logic [2:0]        mask_reads;
   logic              hi_byte;
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic [WORD_W-1:0] pll_word [256];

   task automatic reset_predictor();
      cmd_reg    = '0;
      mask_reads = '0;
      hi_byte    = 1'b0;
      wr_idx     = '0;
      rd_idx     = '0;
      foreach (pll_word[i]) pll_word[i] = '0;
      pll_word[0] = ENTRY0_RESET;
      pll_word[1] = ENTRY1_RESET;
   endtask

   function automatic logic is_writable(input logic [IDX_W-1:0] idx);
      return (idx >= 8'd2 && idx <= 8'd7) || idx == PLL_IDX_EXT || idx == PLL_IDX_CTRL;
   endfunction

   // command upper nibble to depth code
   function automatic logic [DEPTH_W-1:0] depth_of(input logic [DATA_W-1:0] cmd);
      case (cmd[7:4])
         4'h2, 4'h3, 4'h8, 4'ha: return DEPTH_15;
         4'h5, 4'h6, 4'hc:       return DEPTH_16;
         4'h4, 4'h9, 4'he:       return DEPTH_24;
         4'h7:                   return DEPTH_32;
         default:                return DEPTH_8;
      endcase
   endfunction

   // xtal * m / (n1 * 2^n2), truncated
   function automatic logic [HZ_W-1:0] pixel_hz(input logic [SEL_W-1:0] sel);
      logic [SEL_W-1:0]  src;
      logic [WORD_W-1:0] w;
      longint unsigned   m;
      longint unsigned   n1;
      longint unsigned   xtal;
      longint unsigned   quot;
      src = pll_word[PLL_IDX_CTRL][OVR_EN_BIT] ? pll_word[PLL_IDX_CTRL][2:0] : sel;
      if (src == SRC_FIXED0) return CLK0_HZ;
      if (src == SRC_FIXED1) return CLK1_HZ;
      w    = pll_word[src];
      xtal = XTAL_HZ;
      m    = w[6:0];
      m    = m + 2;
      n1   = w[12:8];
      n1   = n1 + 2;
      quot = (xtal * m) / (n1 << w[15:13]);
      return quot[HZ_W-1:0];
   endfunction

   // apply one bus access to the predicted state, return its result
   task automatic predict_access(input logic act, input logic [ADDR_W-1:0] adr,
                                 input logic [DATA_W-1:0] wd, input logic [SEL_W-1:0] sel,
                                 output ramdac_result_type r);
      logic              fwd;
      logic [DATA_W-1:0] rd;
      logic [WORD_W-1:0] w;
      fwd = 1'b0;
      rd  = '0;
      if (act == ACT_WRITE) begin
         case (adr)
            ADDR_PEL_MASK: begin
               if (mask_reads == HIDDEN_ID_COUNT) cmd_reg = wd;
               mask_reads = '0;
            end
            ADDR_PEL_WIDX, ADDR_PEL_DATA, ADDR_PEL_RIDX: mask_reads = '0;
            ADDR_PLL_WIDX: begin
               wr_idx  = wd;
               hi_byte = 1'b0;
            end
            ADDR_PLL_DATA: begin
               if (is_writable(wr_idx)) begin
                  if (hi_byte) pll_word[wr_idx][15:8] = wd;
                  else pll_word[wr_idx][7:0] = wd;
               end
               hi_byte = ~hi_byte;
               if (!hi_byte) wr_idx = wr_idx + 1'b1;
            end
            ADDR_COMMAND: cmd_reg = wd;
            default: begin
               rd_idx  = wd;
               hi_byte = 1'b0;
            end
         endcase
         fwd = (adr < ADDR_PLL_WIDX);
      end else begin
         case (adr)
            ADDR_PEL_MASK: begin
               // unlock count saturates; fourth read gives the ID, fifth the command
               if (mask_reads < HIDDEN_CMD_COUNT) mask_reads = mask_reads + 1'b1;
               if (mask_reads == HIDDEN_ID_COUNT) begin
                  rd = DAC_ID;
               end else if (mask_reads == HIDDEN_CMD_COUNT) begin
                  mask_reads = '0;
                  rd = cmd_reg;
               end else begin
                  fwd = 1'b1;
               end
            end
            ADDR_PEL_WIDX, ADDR_PEL_DATA, ADDR_PEL_RIDX: begin
               mask_reads = '0;
               fwd = 1'b1;
            end
            ADDR_PLL_WIDX: rd = wr_idx;
            ADDR_PLL_DATA: begin
               w  = pll_word[rd_idx];
               rd = hi_byte ? w[15:8] : w[7:0];
               hi_byte = ~hi_byte;
               if (!hi_byte) rd_idx = rd_idx + 1'b1;
            end
            ADDR_COMMAND: rd = cmd_reg;
            default: rd = rd_idx;
         endcase
      end
      r.read_data = rd;
      r.forwarded = fwd;
      if (!fwd) r.vga_port = '0;
      else if (adr < ADDR_PEL_MASK) r.vga_port = VGA_PORT_LOW_BASE + PORT_W'(adr);
      else r.vga_port = VGA_PORT_HIGH_BASE + PORT_W'(adr);
      r.pixel_depth    = depth_of(cmd_reg);
      r.pixel_clock_hz = pixel_hz(sel);
   endtask

   task automatic check_field(input string what, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   // compare accepted results, then queue the prediction of an accepted item
   always @(posedge clock) begin
      ramdac_result_type want;
      ramdac_result_type got;
      if (reset) begin
         reset_predictor();
         pending_results.delete();
         fail_count = 0;
         results_seen <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.read_data      = rsp_ch.read_data;
            got.forwarded      = rsp_ch.forwarded;
            got.vga_port       = rsp_ch.vga_port;
            got.pixel_depth    = rsp_ch.pixel_depth;
            got.pixel_clock_hz = rsp_ch.pixel_clock_hz;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none got %h", $time, got);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("forwarded", want.forwarded, got.forwarded);
               check_field("vga_port", want.vga_port, got.vga_port);
               check_field("pixel_depth", want.pixel_depth, got.pixel_depth);
               check_field("pixel_clock_hz", want.pixel_clock_hz, got.pixel_clock_hz);
            end
            results_seen <= results_seen + 1;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_access(req_ch.action, req_ch.address, req_ch.write_data,
                           req_ch.clock_select, want);
            pending_results.push_back(want);
         end
      end
   end

endmodule

// ----- tb/ramdac_pll_register_interface_unit_tb.sv -----
`timescale 1ns / 100ps

module ramdac_pll_register_interface_unit_tb;
   import rpll_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 45;
   localparam int RANDOM_TARGET  = 525;
   localparam int MAX_IDLE       = 13;

   logic clock;
   logic reset;

   rpll_req_if req_ch();
   rpll_rsp_if rsp_ch();

   int accesses_sent;
   int results_seen;
   int fail_count;
   int cycle_count = 0;
   bit req_idle_on;
   bit rsp_idle_on;
   int rsp_hold;
   int rsp_mode_left;
   bit pressure_done;

   ramdac_pll_register_interface_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rpll_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .results_seen (results_seen),
      .fail_count   (fail_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ramdac_pll_register_interface_unit_tb NOT OK");
         $finish;
      end
   end

   // result side: stall a random number of cycles after each item
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_mode_left = 0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_mode_left == 0) begin
               rsp_idle_on = ($urandom_range(0, 3) != 0);
               rsp_mode_left = 40;
            end
            rsp_mode_left--;
            rsp_hold = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // one bus access item; valid stays high into the next item when there is no gap
   task automatic bus_access(input logic act, input logic [ADDR_W-1:0] adr,
                             input logic [DATA_W-1:0] wd, input logic [SEL_W-1:0] sel);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.address      <= adr;
      req_ch.write_data   <= wd;
      req_ch.clock_select <= sel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      accesses_sent++;
   endtask

   function automatic logic [SEL_W-1:0] any_sel();
      return SEL_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [DATA_W-1:0] any_byte();
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic logic any_act();
      return 1'($urandom_range(0, 1));
   endfunction

   // mostly writable entries, some wrap and read-only ones
   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 9))
         0:       return 8'hff;
         1:       return IDX_W'($urandom_range(0, 1));
         2:       return any_byte();
         3:       return PLL_IDX_EXT;
         4:       return PLL_IDX_CTRL;
         default: return IDX_W'($urandom_range(2, 7));
      endcase
   endfunction

   task automatic wait_all_results();
      while (results_seen != accesses_sent) @(posedge clock);
   endtask

   initial begin
      int n;
      int ending;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_READ;
      req_ch.address = '0;
      req_ch.write_data = '0;
      req_ch.clock_select = '0;
      rsp_ch.ready = 1'b0;
      accesses_sent = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      pressure_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: forwarding on the DAC addresses
      bus_access(ACT_READ, ADDR_PEL_WIDX, 8'h00, SRC_FIXED0);
      bus_access(ACT_WRITE, ADDR_PEL_DATA, 8'hff, SRC_FIXED1);
      bus_access(ACT_READ, ADDR_PEL_RIDX, 8'h00, 3'd7);
      // unlock, ID read, command load through the mask port
      repeat (4) bus_access(ACT_READ, ADDR_PEL_MASK, 8'h00, 3'd2);
      bus_access(ACT_WRITE, ADDR_PEL_MASK, 8'h7f, 3'd2);
      // unlock again, fifth read returns the command
      repeat (5) bus_access(ACT_READ, ADDR_PEL_MASK, 8'h00, 3'd3);
      // entry 3 fastest clock, entry 4 slowest
      bus_access(ACT_WRITE, ADDR_PLL_WIDX, 8'h03, SRC_FIXED0);
      bus_access(ACT_WRITE, ADDR_PLL_DATA, 8'h7f, 3'd3);
      bus_access(ACT_WRITE, ADDR_PLL_DATA, 8'h00, 3'd3);
      bus_access(ACT_WRITE, ADDR_PLL_DATA, 8'hff, 3'd4);
      bus_access(ACT_WRITE, ADDR_PLL_DATA, 8'hff, 3'd4);
      bus_access(ACT_READ, ADDR_PLL_WIDX, 8'h00, 3'd3);
      // read index wraps from 255 to 0
      bus_access(ACT_WRITE, ADDR_PLL_RIDX, 8'hff, 3'd5);
      repeat (3) bus_access(ACT_READ, ADDR_PLL_DATA, 8'h00, 3'd6);
      bus_access(ACT_READ, ADDR_PLL_RIDX, 8'h00, 3'd7);
      bus_access(ACT_WRITE, ADDR_COMMAND, 8'hf0, 3'd6);
      bus_access(ACT_READ, ADDR_COMMAND, 8'h00, 3'd5);

      // random sequences, mostly well formed
      while (accesses_sent < RANDOM_TARGET) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         if (!pressure_done && accesses_sent >= RANDOM_TARGET / 2) begin
            // drop valid so the last item is not offered again while draining
            req_ch.valid <= 1'b0;
            wait_all_results();
            pressure_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1: begin
               // hidden command unlock
               n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 5);
               repeat (n) bus_access(ACT_READ, ADDR_PEL_MASK, any_byte(), any_sel());
               ending = $urandom_range(0, 3);
               if (ending == 0)
                  bus_access(ACT_WRITE, ADDR_PEL_MASK, any_byte(), any_sel());
               else if (ending == 1)
                  bus_access(any_act(), ($urandom_range(0, 1) == 0) ?
                             ADDR_PEL_RIDX : ADDR_W'($urandom_range(0, 1)),
                             any_byte(), any_sel());
            end
            2, 3: begin
               // PLL entry writes, low byte then high byte
               bus_access(ACT_WRITE, ADDR_PLL_WIDX, pick_index(), any_sel());
               n = 2 * $urandom_range(1, 3) + (($urandom_range(0, 7) == 0) ? 1 : 0);
               repeat (n) bus_access(ACT_WRITE, ADDR_PLL_DATA, any_byte(), any_sel());
            end
            4: begin
               // PLL entry reads
               bus_access(ACT_WRITE, ADDR_PLL_RIDX, pick_index(), any_sel());
               repeat ($urandom_range(2, 5))
                  bus_access(ACT_READ, ADDR_PLL_DATA, any_byte(), any_sel());
            end
            5: begin
               // clock source override entry
               bus_access(ACT_WRITE, ADDR_PLL_WIDX, PLL_IDX_CTRL, any_sel());
               bus_access(ACT_WRITE, ADDR_PLL_DATA,
                          ($urandom_range(0, 2) == 0) ? any_byte() : (any_byte() & 8'hdf),
                          any_sel());
               bus_access(ACT_WRITE, ADDR_PLL_DATA, any_byte(), any_sel());
               bus_access(ACT_READ, ADDR_COMMAND, any_byte(), any_sel());
            end
            6: begin
               bus_access(ACT_WRITE, ADDR_COMMAND, any_byte(), any_sel());
               bus_access(ACT_READ, ADDR_COMMAND, any_byte(), any_sel());
            end
            7: begin
               bus_access(ACT_READ, ADDR_PLL_WIDX, any_byte(), any_sel());
               bus_access(ACT_READ, ADDR_PLL_RIDX, any_byte(), any_sel());
            end
            default: begin
               // noise
               repeat ($urandom_range(1, 4))
                  bus_access(any_act(), ADDR_W'($urandom_range(0, 7)), any_byte(),
                             any_sel());
            end
         endcase
      end
      req_ch.valid <= 1'b0;

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_seen == accesses_sent)
         $display("ramdac_pll_register_interface_unit_tb OK");
      else
         $display("ramdac_pll_register_interface_unit_tb NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/rpll_pkg.sv
hw/rtl/rpll_if.sv
hw/rtl/rpll_regs.sv
hw/rtl/rpll_clk.sv
hw/rtl/ramdac_pll_register_interface_unit.sv
hw/rtl/rpll_checker.sv
tb/rpll_checker.sv
tb/ramdac_pll_register_interface_unit_tb.sv
